// ===== sv/pme_bspline_weights_top_assert.svh =====
// ----------------------------------------------------------------------------
// B-spline weight engine: assertion macros
// Shorthand for clocked, reset-qualified assertions used by the weight engine.
// ----------------------------------------------------------------------------
`ifndef PME_BSPLINE_WEIGHTS_TOP_ASSERT_SVH
`define PME_BSPLINE_WEIGHTS_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PBW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PBW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pbw_pkg.sv =====
// ----------------------------------------------------------------------------
// B-spline weight engine: shared package
// Field widths, fixed-point constants, rounding modes and reciprocal table.
// ----------------------------------------------------------------------------
package pbw_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int RECIP_BITS = 24;
    localparam int COEF_W     = 24;

    localparam int CFG_W    = 4;
    localparam int FRAC_W   = 16;
    localparam int AXIS_W   = 2;
    localparam int TAP_W    = 3;
    localparam int WEIGHT_W = FRAC_BITS + 1;
    localparam int SLOPE_W  = FRAC_BITS + 2;

    localparam logic [WEIGHT_W-1:0] ONE_FX  = WEIGHT_W'(1) << FRAC_BITS;
    localparam logic [WEIGHT_W-1:0] HALF_FX = WEIGHT_W'(1) << (FRAC_BITS - 1);

    localparam logic [CFG_W-1:0] MIN_ORDER = 4'd4;

    localparam logic [AXIS_W-1:0] AX_X = 2'd0;
    localparam logic [AXIS_W-1:0] AX_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AX_Z = 2'd2;

    // rounding right shift applied after the shared multiplier
    typedef enum logic [1:0] {
        SH_Q17 = 2'd0,
        SH_Q16 = 2'd1,
        SH_R24 = 2'd2
    } t_shift;

    // round(2^24 / (n - 1)) for each supported order n
    function automatic logic [COEF_W-1:0] f_recip(input logic [CFG_W-1:0] n);
        logic [COEF_W-1:0] r;
        unique case (n)
            4'd4:    r = 24'd5592405;
            4'd5:    r = 24'd4194304;
            4'd6:    r = 24'd3355443;
            4'd7:    r = 24'd2796203;
            4'd8:    r = 24'd2396745;
            4'd9:    r = 24'd2097152;
            4'd10:   r = 24'd1864135;
            4'd11:   r = 24'd1677722;
            4'd12:   r = 24'd1525201;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/pme_bspline_weights_top.sv =====
// ----------------------------------------------------------------------------
// B-spline weight engine for smooth particle-mesh Ewald
// Computes cardinal B-spline weights and slopes along x, y and z for one
// set of fractional grid offsets, on one shared multiplier.
// ----------------------------------------------------------------------------
//
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+--------------------------
// command   | start, busy, i_frac_x/y/z               | taken when start & !busy
// result    | o_strobe, o_axis, o_tap_index,          | one-cycle strobe, no
//           | o_weight, o_slope, o_last               | back-pressure
// config    | i_cfg_we, i_cfg_wdata                   | written when i_cfg_we
//
// Sequencing: one shared multiplier serves every step. Each weight of each
//   order step takes two products, the sum, the reciprocal product and the
//   write back, and each axis opens with three quadratic start values,
//   each a product and a write.
// Reset: synchronous, active low; clears the sequencer and the strobe and
//   sets the order register to 4. No clearing pass is needed.
// Stalls: the receiver cannot stall. Results of an axis leave during its last
//   order step, one per weight, x first, then y, then z.
// ----------------------------------------------------------------------------
`include "pme_bspline_weights_top_assert.svh"

module pme_bspline_weights_top #(
    parameter int MAX_ORDER = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pbw_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic                                start,
    output logic                                busy,
    input  logic [pbw_pkg::FRAC_W-1:0]          i_frac_x,
    input  logic [pbw_pkg::FRAC_W-1:0]          i_frac_y,
    input  logic [pbw_pkg::FRAC_W-1:0]          i_frac_z,
    output logic                                o_strobe,
    output logic [pbw_pkg::AXIS_W-1:0]          o_axis,
    output logic [pbw_pkg::TAP_W-1:0]           o_tap_index,
    output logic [pbw_pkg::WEIGHT_W-1:0]        o_weight,
    output logic signed [pbw_pkg::SLOPE_W-1:0]  o_slope,
    output logic                                o_last
);
    import pbw_pkg::*;

    localparam int ORD_W = $clog2(MAX_ORDER + 1);
    localparam int IDX_W = $clog2(MAX_ORDER);
    localparam int A_W   = ORD_W + FRAC_BITS;
    localparam int D_W   = ORD_W + FRAC_BITS + 2;
    localparam int P_W   = D_W + COEF_W;

    localparam logic [CFG_W-1:0] MAX_ORD_CFG = CFG_W'(MAX_ORDER);

    // quadratic start value being built: M1, M2, M3
    localparam logic [1:0] QIDX_M1 = 2'd0;
    localparam logic [1:0] QIDX_M2 = 2'd1;
    localparam logic [1:0] QIDX_M3 = 2'd2;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,  // wait for a command
        S_QMUL = 8'b0000_0010,  // quadratic start product
        S_QWR  = 8'b0000_0100,  // write quadratic start value
        S_PA   = 8'b0000_1000,  // (x + j) * M[k-1]
        S_PB   = 8'b0001_0000,  // (n - x - j) * M[k]
        S_PS   = 8'b0010_0000,  // sum both products
        S_PC   = 8'b0100_0000,  // scale by 1/(n-1)
        S_PW   = 8'b1000_0000   // write new M[k], emit on last step
    } t_state;

    t_state r_state, n_state;

    logic [CFG_W-1:0]    r_cfg;
    logic [FRAC_W-1:0]   r_fx, r_fy, r_fz;
    logic [ORD_W-1:0]    r_ord, r_n, r_k;
    logic [AXIS_W-1:0]   r_ax;
    logic [1:0]          r_q;
    logic [WEIGHT_W-1:0] r_m [MAX_ORDER];
    logic [WEIGHT_W-1:0] r_prev;   // old M[k-1] of the running order step
    logic [D_W-1:0]      r_acc;
    logic [D_W-1:0]      r_prod;

    logic                r_strobe;
    logic [AXIS_W-1:0]   r_axis;
    logic [TAP_W-1:0]    r_tap;
    logic [WEIGHT_W-1:0] r_weight;
    logic [SLOPE_W-1:0]  r_slope;
    logic                r_last;

    logic [FRAC_W-1:0]   w_x;
    logic [WEIGHT_W-1:0] w_x1;
    logic [CFG_W-1:0]    w_ord_clamp;
    logic [ORD_W-1:0]    w_ord_eff;
    logic [ORD_W-1:0]    w_km1;
    logic [ORD_W-1:0]    w_nmk;
    logic [IDX_W-1:0]    w_kidx;
    logic [WEIGHT_W-1:0] w_old_k;
    logic [A_W-1:0]      w_a;
    logic [A_W-1:0]      w_b;
    logic [COEF_W-1:0]   w_recip;
    logic [D_W-1:0]      w_op_d;
    logic [COEF_W-1:0]   w_op_c;
    t_shift              w_shift;
    logic [P_W-1:0]      w_prod;
    logic [P_W-1:0]      w_bias;
    logic [P_W-1:0]      w_sum;
    logic [D_W-1:0]      w_rnd;
    logic [D_W-1:0]      w_wraw;
    logic [WEIGHT_W-1:0] w_wval;
    logic [SLOPE_W-1:0]  w_slope;
    logic                w_pass_end;
    logic                w_final;
    logic                w_item_end;

    // ------------------------------------------------------------------
    // Order clamp: below 4 acts as 4, above MAX_ORDER as MAX_ORDER
    // ------------------------------------------------------------------
    always_comb begin
        priority if (r_cfg < MIN_ORDER) begin
            w_ord_clamp = MIN_ORDER;
        end else if (r_cfg > MAX_ORD_CFG) begin
            w_ord_clamp = MAX_ORD_CFG;
        end else begin
            w_ord_clamp = r_cfg;
        end
    end
    assign w_ord_eff = ORD_W'(w_ord_clamp);

    // ------------------------------------------------------------------
    // Per-axis operands
    // ------------------------------------------------------------------
    always_comb begin
        unique case (r_ax)
            AX_X:    w_x = r_fx;
            AX_Y:    w_x = r_fy;
            default: w_x = r_fz;
        endcase
    end

    assign w_x1   = ONE_FX - WEIGHT_W'(w_x);
    assign w_km1  = r_k - ORD_W'(1);
    assign w_kidx = w_km1[IDX_W-1:0];
    assign w_nmk  = r_n - r_k;

    // M[n] of the previous order is zero; it was never written this axis
    assign w_old_k = (r_k == r_n) ? '0 : r_m[w_kidx];

    // x + j and (n - j) - x with j = n - k; x stays below one
    assign w_a = {w_nmk, w_x};
    assign w_b = {r_k, {FRAC_BITS{1'b0}}} - A_W'(w_x);

    assign w_recip = f_recip(CFG_W'(r_n));

    assign w_pass_end = (r_k == r_n);
    assign w_final    = (r_n == r_ord);
    assign w_item_end = w_pass_end && w_final && (r_ax == AX_Z);

    // ------------------------------------------------------------------
    // Shared multiplier operand select
    // ------------------------------------------------------------------
    always_comb begin
        w_op_d  = '0;
        w_op_c  = '0;
        w_shift = SH_Q16;
        unique case (r_state)
            S_QMUL: begin
                unique case (r_q)
                    QIDX_M1: begin
                        w_op_d  = D_W'(w_x1);
                        w_op_c  = COEF_W'(w_x1);
                        w_shift = SH_Q17;
                    end
                    QIDX_M2: begin
                        w_op_d  = D_W'(w_x1);
                        w_op_c  = COEF_W'(w_x);
                        w_shift = SH_Q16;
                    end
                    default: begin
                        w_op_d  = D_W'(w_x);
                        w_op_c  = COEF_W'(w_x);
                        w_shift = SH_Q17;
                    end
                endcase
            end
            S_PA: begin
                w_op_d  = D_W'(w_a);
                w_op_c  = COEF_W'(r_prev);
                w_shift = SH_Q16;
            end
            S_PB: begin
                w_op_d  = D_W'(w_b);
                w_op_c  = COEF_W'(w_old_k);
                w_shift = SH_Q16;
            end
            S_PC: begin
                w_op_d  = r_acc;
                w_op_c  = w_recip;
                w_shift = SH_R24;
            end
            default: begin
                w_op_d  = '0;
                w_op_c  = '0;
                w_shift = SH_Q16;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Multiply, round to nearest (ties up), shift
    // ------------------------------------------------------------------
    assign w_prod = P_W'(w_op_d) * P_W'(w_op_c);

    always_comb begin
        unique case (w_shift)
            SH_Q17:  w_bias = P_W'(1) << FRAC_BITS;
            SH_R24:  w_bias = P_W'(1) << (RECIP_BITS - 1);
            default: w_bias = P_W'(1) << (FRAC_BITS - 1);
        endcase
    end

    assign w_sum = w_prod + w_bias;

    always_comb begin
        unique case (w_shift)
            SH_Q17:  w_rnd = w_sum[FRAC_BITS + 1 +: D_W];
            SH_R24:  w_rnd = w_sum[RECIP_BITS +: D_W];
            default: w_rnd = w_sum[FRAC_BITS +: D_W];
        endcase
    end

    // ------------------------------------------------------------------
    // Write-back value: add one half for M2, then saturate at one
    // ------------------------------------------------------------------
    assign w_wraw = ((r_state == S_QWR) && (r_q == QIDX_M2)) ?
                    r_prod + D_W'(HALF_FX) : r_prod;
    assign w_wval = (w_wraw > D_W'(ONE_FX)) ? ONE_FX : w_wraw[WEIGHT_W-1:0];

    // slope from the order-1 weights: M[k-1] - M[k]
    assign w_slope = SLOPE_W'(r_prev) - SLOPE_W'(w_old_k);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (start) begin
                n_state = S_QMUL;
            end
            S_QMUL: n_state = S_QWR;
            S_QWR: begin
                n_state = (r_q == QIDX_M3) ? S_PA : S_QMUL;
            end
            S_PA: n_state = S_PB;
            S_PB: n_state = S_PS;
            S_PS: n_state = S_PC;
            S_PC: n_state = S_PW;
            S_PW: begin
                priority if (!w_pass_end || !w_final) begin
                    n_state = S_PA;
                end else if (r_ax != AX_Z) begin
                    n_state = S_QMUL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_cfg    <= MIN_ORDER;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_PW) && w_final;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_prod <= w_rnd;
        unique case (r_state)
            S_IDLE: if (start) begin
                // latch the item and the order for its whole run
                r_fx  <= i_frac_x;
                r_fy  <= i_frac_y;
                r_fz  <= i_frac_z;
                r_ord <= w_ord_eff;
                r_ax  <= AX_X;
                r_q   <= QIDX_M1;
            end
            S_QWR: begin
                r_m[IDX_W'(r_q)] <= w_wval;
                if (r_q == QIDX_M3) begin
                    r_n    <= ORD_W'(MIN_ORDER);
                    r_k    <= ORD_W'(1);
                    r_prev <= '0;
                end else begin
                    r_q <= r_q + 2'd1;
                end
            end
            S_PB: r_acc <= r_prod;
            S_PS: r_acc <= r_acc + r_prod;
            S_PW: begin
                r_m[w_kidx] <= w_wval;
                // restart at M[1] with a zero M[0] once the order step ends
                r_prev      <= w_pass_end ? '0 : w_old_k;
                if (w_final) begin
                    r_axis   <= r_ax;
                    r_tap    <= w_km1[TAP_W-1:0];
                    r_weight <= w_wval;
                    r_slope  <= w_slope;
                    r_last   <= w_item_end;
                end
                priority if (!w_pass_end) begin
                    r_k <= r_k + ORD_W'(1);
                end else if (!w_final) begin
                    // advance to the next order, restart at M[1]
                    r_n    <= r_n + ORD_W'(1);
                    r_k    <= ORD_W'(1);
                end else if (r_ax != AX_Z) begin
                    r_ax <= r_ax + AX_Y;
                    r_q  <= QIDX_M1;
                end
            end
            default: ;
        endcase
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_axis      = r_axis;
    assign o_tap_index = r_tap;
    assign o_weight    = r_weight;
    assign o_slope     = r_slope;
    assign o_last      = r_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PBW_ASSERT_NOW(a_weight_sat, o_strobe, o_weight <= ONE_FX, "weight above one")
    `PBW_ASSERT_NOW(a_last_on_z, o_strobe && o_last, o_axis == AX_Z, "last item not on z")
    `PBW_ASSERT_NOW(a_last_ends, o_strobe && o_last, !busy, "busy after last item")
    `PBW_ASSERT_NOW(a_mid_busy, o_strobe && !o_last, busy, "idle before last item")
    `PBW_ASSERT_NEXT(a_start_busy, start && !busy, busy, "command not taken")

endmodule
